FILE: rtl/sbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

  // Width of a table entry and of a byte code.
  localparam int unsigned CodeW = 8;
  // Largest table the byte codes can address.
  localparam int unsigned StoreDepth = 256;
  // Default number of permuted entries.
  localparam int unsigned TableEntriesDef = 256;
  // Width of a shuffle divisor, which reaches StoreDepth.
  localparam int unsigned DivW = 9;

  localparam int unsigned MixShift = 33;
  localparam logic [63:0] MixMulA = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixMulB = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd = 64'd1442695040888963407;

  typedef enum logic [1:0] {
    MUL_MIX_A,
    MUL_MIX_B,
    MUL_LCG
  } mul_sel_e;

  typedef struct packed {
    logic        start;
    mul_sel_e    sel;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [63:0]     dividend;
    logic [DivW-1:0] divisor;
  } mod_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX1_W,
    ST_MIX2,
    ST_MIX2_W,
    ST_MIX3,
    ST_LCG,
    ST_LCG_W,
    ST_MOD_W,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_INV_RD,
    ST_INV_WR,
    ST_LOOK,
    ST_DONE
  } state_e;

  function automatic logic [63:0] mul_const(input mul_sel_e sel);
    logic [63:0] k;
    unique case (sel)
      MUL_MIX_A: k = MixMulA;
      MUL_MIX_B: k = MixMulB;
      MUL_LCG:   k = LcgMul;
      default:   k = LcgMul;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sbp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbp_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] seed;
  logic [7:0]  code_in;

  modport source(output valid, output kind, output seed, output code_in, input ready);
  modport sink(input valid, input kind, input seed, input code_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] forward_code;
  logic [7:0] inverse_code;
  logic       generate_done;

  modport source(output valid, output forward_code, output inverse_code,
                 output generate_done, input ready);
  modport sink(input valid, input forward_code, input inverse_code,
               input generate_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/sbp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative 64 x 64 multiply modulo 2^64 on one 32 x 32 multiplier,
// with an optional constant addend folded into the first partial sum.
module sbp_mul
  import sbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mul_req_t    req_i,
  output logic             done_o,
  output logic [63:0]      product_o
);

  logic        busy_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [63:0] a_q;
  logic [63:0] k_q;
  logic [63:0] add_q;
  logic [63:0] pp_q;
  logic [63:0] acc_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] pp_d;

  // Step 0: lo*lo, step 1: lo(a)*hi(k), step 2: hi(a)*lo(k).
  always_comb begin
    op_a = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    op_b = (step_q == 2'd1) ? k_q[63:32] : k_q[31:0];
    pp_d = op_a * op_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.operand;
      k_q   <= mul_const(req_i.sel);
      add_q <= (req_i.sel == MUL_LCG) ? LcgAdd : 64'd0;
    end else if (busy_q) begin
      pp_q <= pp_d;
      case (step_q)
        2'd1:    acc_q <= add_q + pp_q;
        2'd2:    acc_q <= acc_q + {pp_q[31:0], 32'd0};
        2'd3:    acc_q <= acc_q + {pp_q[31:0], 32'd0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

FILE: rtl/sbp_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial remainder of a 64-bit dividend by a small divisor,
// one dividend bit per cycle.
module sbp_mod
  import sbp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mod_req_t        req_i,
  output logic                 done_o,
  output logic [DivW-1:0]      rem_o
);

  logic            busy_q;
  logic [5:0]      cnt_q;
  logic            done_q;
  logic [63:0]     sh_q;
  logic [DivW-1:0] div_q;
  logic [DivW-1:0] rem_q;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic [DivW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, sh_q[63]};
    diff  = trial - {1'b0, div_q};
    rem_d = (trial >= {1'b0, div_q}) ? diff[DivW-1:0] : trial[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[62:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/sbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte table with one write and one registered read port. An entry that
// has not been written since the last clear reads as its own address.
module sbp_ram
  import sbp_pkg::*;
#(
  parameter int unsigned Depth = TableEntriesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [CodeW-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [CodeW-1:0]              rdata_o
);

  logic [CodeW-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [CodeW-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : CodeW'(raddr_i);
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/seeded_byte_permutation_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Seeded byte permutation core.
// Requests arrive on req_i (valid/ready); each accepted transfer gives exactly
// one response transfer on rsp_o. A request of kind 0 regenerates the forward
// and inverse byte tables from its 64-bit seed and answers with generate_done
// set and both codes zero. A request of kind 1 answers with the forward and
// inverse images of code_in; codes at or beyond TABLE_ENTRIES map to themselves.
// One request is worked on at a time and req_i.ready is high only while idle.
// A lookup reads both tables in ST_LOOK and loads the response in ST_DONE.
// A regeneration does seed mixing, then TABLE_ENTRIES-1 shuffle steps, then
// rebuilds the inverse table one entry at a time. A shuffle step uses the
// shared 32 x 32 multiplier, then the bit-serial remainder unit, then a swap
// in the forward table.
// The response sits in an output register; if the receiver stalls, a finished
// response waits for it. The next request can still be taken and worked on, but
// it cannot finish, and no further request is accepted, until that slot frees.
// Reset returns both tables to identity at once (per-entry valid bits),
// clears the generator state, and leaves the core idle with no response pending.
module seeded_byte_permutation_core
  import sbp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sbp_req_if.sink    req_i,
  sbp_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [DivW-1:0] EntriesW = DivW'(TABLE_ENTRIES);

  // Sequencer state and the working registers of a request.
  state_e         state_q, state_d;
  logic [63:0]    gen_q, gen_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [IdxW-1:0] k_q, k_d;
  logic [CodeW-1:0] ti_q, ti_d;
  logic           kind_q, kind_d;
  logic [CodeW-1:0] code_q, code_d;
  logic           out_range_q, out_range_d;

  // Response register.
  logic             rsp_valid_q, rsp_valid_d;
  logic [CodeW-1:0] rsp_fwd_q, rsp_fwd_d;
  logic [CodeW-1:0] rsp_inv_q, rsp_inv_d;
  logic             rsp_done_q, rsp_done_d;

  // Arithmetic units; the multiplier is shared by seed mixing and the shuffle.
  mul_req_t        mul_req;
  logic            mul_done;
  logic [63:0]     mul_product;
  mod_req_t        mod_req;
  logic            mod_done;
  logic [DivW-1:0] mod_rem;

  // Table ports.
  logic             tbl_clear;
  logic             fwd_we, fwd_re;
  logic [IdxW-1:0]  fwd_waddr, fwd_raddr;
  logic [CodeW-1:0] fwd_wdata, fwd_rdata;
  logic             inv_we, inv_re;
  logic [IdxW-1:0]  inv_waddr, inv_raddr;
  logic [CodeW-1:0] inv_wdata, inv_rdata;

  logic [63:0] xorshift;
  logic        req_fire;
  logic        rsp_free;

  assign xorshift = gen_q ^ (gen_q >> MixShift);
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    pos_d       = pos_q;
    j_d         = j_q;
    k_d         = k_q;
    ti_d        = ti_q;
    kind_d      = kind_q;
    code_d      = code_q;
    out_range_d = out_range_q;

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_fwd_d   = rsp_fwd_q;
    rsp_inv_d   = rsp_inv_q;
    rsp_done_d  = rsp_done_q;

    mul_req.start   = 1'b0;
    mul_req.sel     = MUL_LCG;
    mul_req.operand = gen_q;
    mod_req.start    = 1'b0;
    mod_req.dividend = mul_product;
    mod_req.divisor  = DivW'(pos_q) + DivW'(1);

    tbl_clear = 1'b0;
    fwd_we    = 1'b0;
    fwd_waddr = pos_q;
    fwd_wdata = fwd_rdata;
    fwd_re    = 1'b0;
    fwd_raddr = pos_q;
    inv_we    = 1'b0;
    inv_waddr = fwd_rdata[IdxW-1:0];
    inv_wdata = CodeW'(k_q);
    inv_re    = 1'b0;
    inv_raddr = code_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d      = req_i.kind;
          code_d      = req_i.code_in;
          out_range_d = ({1'b0, req_i.code_in} >= EntriesW);
          if (!req_i.kind) begin
            gen_d     = req_i.seed;
            tbl_clear = 1'b1;
            state_d   = ST_MIX1;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      // Finalizer: xor-shift, multiply, xor-shift, multiply, xor-shift.
      ST_MIX1: begin
        gen_d           = xorshift;
        mul_req.start   = 1'b1;
        mul_req.sel     = MUL_MIX_A;
        mul_req.operand = xorshift;
        state_d         = ST_MIX1_W;
      end
      ST_MIX1_W: begin
        if (mul_done) begin
          gen_d   = mul_product;
          state_d = ST_MIX2;
        end
      end
      ST_MIX2: begin
        gen_d           = xorshift;
        mul_req.start   = 1'b1;
        mul_req.sel     = MUL_MIX_B;
        mul_req.operand = xorshift;
        state_d         = ST_MIX2_W;
      end
      ST_MIX2_W: begin
        if (mul_done) begin
          gen_d   = mul_product;
          state_d = ST_MIX3;
        end
      end
      ST_MIX3: begin
        gen_d   = xorshift;
        pos_d   = LastIdx;
        state_d = ST_LCG;
      end
      // One shuffle step: advance the generator, reduce, swap.
      ST_LCG: begin
        mul_req.start = 1'b1;
        mul_req.sel   = MUL_LCG;
        state_d       = ST_LCG_W;
      end
      ST_LCG_W: begin
        if (mul_done) begin
          gen_d         = mul_product;
          mod_req.start = 1'b1;
          state_d       = ST_MOD_W;
        end
      end
      ST_MOD_W: begin
        if (mod_done) begin
          j_d     = mod_rem[IdxW-1:0];
          state_d = ST_RD_I;
        end
      end
      ST_RD_I: begin
        fwd_re    = 1'b1;
        fwd_raddr = pos_q;
        state_d   = ST_RD_J;
      end
      ST_RD_J: begin
        ti_d      = fwd_rdata;
        fwd_re    = 1'b1;
        fwd_raddr = j_q;
        state_d   = ST_WR_I;
      end
      ST_WR_I: begin
        fwd_we    = 1'b1;
        fwd_waddr = pos_q;
        fwd_wdata = fwd_rdata;
        state_d   = ST_WR_J;
      end
      ST_WR_J: begin
        fwd_we    = 1'b1;
        fwd_waddr = j_q;
        fwd_wdata = ti_q;
        if (pos_q == IdxW'(1)) begin
          pos_d   = '0;
          k_d     = '0;
          state_d = ST_INV_RD;
        end else begin
          pos_d   = pos_q - IdxW'(1);
          state_d = ST_LCG;
        end
      end
      // Inverse rebuild: inverse[forward[k]] = k for every entry.
      ST_INV_RD: begin
        fwd_re    = 1'b1;
        fwd_raddr = k_q;
        state_d   = ST_INV_WR;
      end
      ST_INV_WR: begin
        inv_we    = 1'b1;
        inv_waddr = fwd_rdata[IdxW-1:0];
        inv_wdata = CodeW'(k_q);
        if (k_q == LastIdx) begin
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + IdxW'(1);
          state_d = ST_INV_RD;
        end
      end
      ST_LOOK: begin
        fwd_re    = !out_range_q;
        fwd_raddr = code_q[IdxW-1:0];
        inv_re    = !out_range_q;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          if (!kind_q) begin
            rsp_fwd_d  = '0;
            rsp_inv_d  = '0;
            rsp_done_d = 1'b1;
          end else begin
            rsp_fwd_d  = out_range_q ? code_q : fwd_rdata;
            rsp_inv_d  = out_range_q ? code_q : inv_rdata;
            rsp_done_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= '0;
      pos_q       <= '0;
      kind_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      pos_q       <= pos_d;
      kind_q      <= req_fire ? kind_d : kind_q;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    k_q         <= k_d;
    ti_q        <= ti_d;
    code_q      <= code_d;
    out_range_q <= out_range_d;
    rsp_fwd_q   <= rsp_fwd_d;
    rsp_inv_q   <= rsp_inv_d;
    rsp_done_q  <= rsp_done_d;
  end

  sbp_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  sbp_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  sbp_ram #(
    .Depth (TABLE_ENTRIES)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (tbl_clear),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .re_i    (fwd_re),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  sbp_ram #(
    .Depth (TABLE_ENTRIES)
  ) u_inv_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (tbl_clear),
    .we_i    (inv_we),
    .waddr_i (inv_waddr),
    .wdata_i (inv_wdata),
    .re_i    (inv_re),
    .raddr_i (inv_raddr),
    .rdata_o (inv_rdata)
  );

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.forward_code  = rsp_fwd_q;
  assign rsp_o.inverse_code  = rsp_inv_q;
  assign rsp_o.generate_done = rsp_done_q;

endmodule

`default_nettype wire
